// ===== rtl/core/stpwm_pkg.sv =====
// Shared types, constants and the quarter-wave sine table generator for the
// sine-triangle PWM generator. No dependencies.
`default_nettype none

package stpwm_pkg;

    localparam int PHASE_BITS_DEF = 32;
    localparam int TABLE_BITS_DEF = 10;
    localparam int COUNT_BITS_DEF = 24;

    localparam int CFG_W   = 32;   // widest configuration register
    localparam int IDX_W   = 3;
    localparam int GAIN_W  = 16;
    localparam int TOTAL_W = 24;
    localparam int LEVEL_W = 16;
    localparam int ROM_W   = 15;   // table holds magnitudes 0..32767

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd31130;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef enum logic [IDX_W-1:0] {
        CFG_SINE_STEP     = 3'd0,
        CFG_CARRIER_STEP  = 3'd1,
        CFG_SINE_GAIN     = 3'd2,
        CFG_SAMPLE_TOTAL  = 3'd3,
        CFG_SINE_START    = 3'd4,
        CFG_CARRIER_START = 3'd5
    } t_cfg_idx;

    // Stage-one result passed from the run control to the output stage
    typedef struct packed {
        logic                      neg;
        logic signed [LEVEL_W-1:0] carrier;
        logic                      running;
        logic                      last;
    } t_s1;

    // term * x^2 in Q30, before the factorial step
    function automatic longint unsigned taylor_raise(input longint unsigned term,
                                                     input longint unsigned x);
        longint unsigned t;
        t = (term * x) >> 30;
        return (t * x) >> 30;
    endfunction

    // round(32767 * sin((2k+1) * pi / 2^(tbits+2))), Q30 Taylor series to x^13.
    // Elaboration only.
    function automatic logic [ROM_W-1:0] table_entry(input int unsigned k,
                                                     input int unsigned tbits);
        longint unsigned x;
        longint unsigned term;
        longint unsigned r;
        longint          sum;
        x    = (64'(2 * k + 1) * PI_Q30) >> (tbits + 2);
        term = x;
        sum  = longint'(x);
        term = taylor_raise(term, x) / 64'd6;
        sum  = sum - longint'(term);
        term = taylor_raise(term, x) / 64'd20;
        sum  = sum + longint'(term);
        term = taylor_raise(term, x) / 64'd42;
        sum  = sum - longint'(term);
        term = taylor_raise(term, x) / 64'd72;
        sum  = sum + longint'(term);
        term = taylor_raise(term, x) / 64'd110;
        sum  = sum - longint'(term);
        term = taylor_raise(term, x) / 64'd156;
        sum  = sum + longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        r = (64'(sum) * 64'd32767 + 64'd536870912) >> 30;
        return (r > 64'd32767) ? 15'h7fff : r[ROM_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/stpwm_in_if.sv =====
// Tick channel: valid/ready handshake carrying the restart flag.
// No dependencies.
`default_nettype none

interface stpwm_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/stpwm_out_if.sv =====
// Result channel: valid/ready handshake carrying drive, levels and run flags.
// No dependencies.
`default_nettype none

interface stpwm_out_if;
    logic              valid;
    logic              ready;
    logic              drive;
    logic signed [15:0] sine_level;
    logic signed [15:0] carrier_level;
    logic              last;
    logic              running;

    modport source (output valid, output drive, output sine_level, output carrier_level,
                    output last, output running, input ready);
    modport sink   (input valid, input drive, input sine_level, input carrier_level,
                    input last, input running, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/stpwm_sine_rom.sv =====
// Quarter-wave sine ROM with registered read port.
// Depends on stpwm_pkg (table generator).
`default_nettype none

module stpwm_sine_rom #(
    parameter int TABLE_BITS = stpwm_pkg::TABLE_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic [TABLE_BITS-1:0]          i_addr,
    output logic      [stpwm_pkg::ROM_W-1:0]    o_data
);
    import stpwm_pkg::*;

    localparam int Depth = 1 << TABLE_BITS;

    logic [ROM_W-1:0] w_rom [Depth];
    logic [ROM_W-1:0] r_data;

    for (genvar k = 0; k < Depth; k++) begin : g_entry
        localparam logic [ROM_W-1:0] EntryVal = table_entry(k, TABLE_BITS);
        assign w_rom[k] = EntryVal;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= w_rom[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ===== rtl/core/stpwm_ctrl.sv =====
// Run control: phase accumulators, tick counter, ROM address and triangle carrier.
// Depends on stpwm_pkg.
`default_nettype none

module stpwm_ctrl #(
    parameter int PHASE_BITS = stpwm_pkg::PHASE_BITS_DEF,
    parameter int TABLE_BITS = stpwm_pkg::TABLE_BITS_DEF,
    parameter int COUNT_BITS = stpwm_pkg::COUNT_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_accept,
    input  wire logic                           i_restart,
    input  wire logic                           i_s1_en,
    input  wire logic [stpwm_pkg::CFG_W-1:0]    i_sine_step,
    input  wire logic [stpwm_pkg::CFG_W-1:0]    i_carrier_step,
    input  wire logic [stpwm_pkg::TOTAL_W-1:0]  i_sample_total,
    input  wire logic [stpwm_pkg::CFG_W-1:0]    i_sine_start,
    input  wire logic [stpwm_pkg::CFG_W-1:0]    i_carrier_start,
    output logic      [TABLE_BITS-1:0]          o_rom_addr,
    output logic                                o_rom_en,
    output stpwm_pkg::t_s1                      o_s1,
    output logic                                o_s1_valid
);
    import stpwm_pkg::*;

    logic [PHASE_BITS-1:0] r_sph, n_sph;
    logic [PHASE_BITS-1:0] r_cph, n_cph;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic                  r_act, n_act;
    t_s1                   r_s1;
    logic                  r_s1_valid;

    logic [PHASE_BITS-1:0] w_sph;
    logic [PHASE_BITS-1:0] w_cph;
    logic [COUNT_BITS-1:0] w_cnt;
    logic [COUNT_BITS-1:0] w_total;
    logic                  w_act;
    logic                  w_last;
    logic [1:0]            w_quad;
    logic [TABLE_BITS-1:0] w_idx;
    logic [15:0]           w_u;
    logic [14:0]           w_v;
    t_s1                   w_s1;

    assign w_total = COUNT_BITS'(i_sample_total);

    // restart reloads before the tick is processed
    always_comb begin
        w_sph  = i_restart ? PHASE_BITS'(i_sine_start)    : r_sph;
        w_cph  = i_restart ? PHASE_BITS'(i_carrier_start) : r_cph;
        w_cnt  = i_restart ? '0 : r_cnt;
        w_act  = i_restart ? (w_total != '0) : r_act;
        w_last = ({1'b0, w_cnt} + (COUNT_BITS + 1)'(1)) >= {1'b0, w_total};
    end

    always_comb begin
        n_sph = r_sph;
        n_cph = r_cph;
        n_cnt = r_cnt;
        n_act = r_act;
        if (i_accept) begin
            n_sph = w_act ? w_sph + PHASE_BITS'(i_sine_step)    : w_sph;
            n_cph = w_act ? w_cph + PHASE_BITS'(i_carrier_step) : w_cph;
            n_cnt = w_act ? w_cnt + COUNT_BITS'(1)              : w_cnt;
            n_act = w_act && !w_last;
        end
    end

    // ROM address, mirrored in quadrants 1 and 3
    always_comb begin
        w_quad     = w_sph[PHASE_BITS-1 -: 2];
        w_idx      = w_sph[PHASE_BITS-3 -: TABLE_BITS];
        o_rom_addr = w_quad[0] ? ~w_idx : w_idx;
    end

    // Triangle: 2v - 32767 taken modulo 2^16
    always_comb begin
        w_u             = w_cph[PHASE_BITS-1 -: 16];
        w_v             = w_u[15] ? ~w_u[14:0] : w_u[14:0];
        w_s1.neg        = w_quad[1];
        w_s1.carrier    = LEVEL_W'({w_v, 1'b0} + 16'd32769);
        w_s1.running    = w_act;
        w_s1.last       = w_act && w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sph      <= '0;
            r_cph      <= '0;
            r_cnt      <= '0;
            r_act      <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_sph <= n_sph;
            r_cph <= n_cph;
            r_cnt <= n_cnt;
            r_act <= n_act;
            if (i_s1_en) begin
                r_s1_valid <= i_accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s1_en) begin
            r_s1 <= w_s1;
        end
    end

    assign o_rom_en   = i_s1_en;
    assign o_s1       = r_s1;
    assign o_s1_valid = r_s1_valid;

    a_last_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && w_act && w_last) |=> !r_act)
        else $error("run still active after its final tick");

    a_zero_run_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_restart && (w_total == '0)) |=> (!r_act && r_cnt == '0))
        else $error("zero length run did not leave the block idle");

    a_idle_holds_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_restart && !r_act) |=> $stable(r_sph) && $stable(r_cph))
        else $error("phase advanced on an idle tick");

endmodule

`default_nettype wire

// ===== rtl/core/stpwm_out.sv =====
// Output stage: gain scaling with rounding and saturation, comparison with the
// carrier, and the result register. Depends on stpwm_pkg and stpwm_out_if.
`default_nettype none

module stpwm_out (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s1_valid,
    input  wire stpwm_pkg::t_s1                 i_s1,
    input  wire logic [stpwm_pkg::ROM_W-1:0]    i_rom_data,
    input  wire logic [stpwm_pkg::GAIN_W-1:0]   i_gain,
    output logic                                o_s2_en,
    stpwm_out_if.source                         o_result
);
    import stpwm_pkg::*;

    logic                      r_valid;
    logic                      r_drive;
    logic signed [LEVEL_W-1:0] r_sine;
    logic signed [LEVEL_W-1:0] r_carrier;
    logic                      r_last;
    logic                      r_running;

    logic [30:0]               w_prod;
    logic [31:0]               w_round;
    logic [16:0]               w_mag;
    logic signed [LEVEL_W-1:0] w_scaled;
    logic signed [LEVEL_W-1:0] w_sine;
    logic signed [LEVEL_W-1:0] w_carrier;
    logic                      w_drive;

    assign o_s2_en = !r_valid || o_result.ready;

    always_comb begin
        w_prod  = 31'(i_rom_data) * 31'(i_gain);
        w_round = 32'(w_prod) + 32'd16384;
        w_mag   = w_round[31:15];
        if (i_s1.neg) begin
            w_scaled = (w_mag > 17'd32768) ? 16'sh8000 : LEVEL_W'(17'd0 - w_mag);
        end else begin
            w_scaled = (w_mag > 17'd32767) ? 16'sh7fff : w_mag[LEVEL_W-1:0];
        end
        w_sine    = i_s1.running ? w_scaled : '0;
        w_carrier = i_s1.running ? i_s1.carrier : '0;
        w_drive   = i_s1.running && (w_sine > w_carrier);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s2_en) begin
            r_valid <= i_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s2_en) begin
            r_drive   <= w_drive;
            r_sine    <= w_sine;
            r_carrier <= w_carrier;
            r_last    <= i_s1.last;
            r_running <= i_s1.running;
        end
    end

    assign o_result.valid         = r_valid;
    assign o_result.drive         = r_drive;
    assign o_result.sine_level    = r_sine;
    assign o_result.carrier_level = r_carrier;
    assign o_result.last          = r_last;
    assign o_result.running       = r_running;

    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s1_valid && o_s2_en) |=> r_valid)
        else $error("stage-one item lost on its way to the result register");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_running) |-> (!r_drive && !r_last && r_sine == '0 && r_carrier == '0))
        else $error("idle tick produced non-zero result");

endmodule

`default_nettype wire

// ===== rtl/core/sine_triangle_pwm_generator.sv =====
// Sine-triangle PWM generator: top level with configuration registers.
// Depends on stpwm_pkg, stpwm_in_if, stpwm_out_if, stpwm_ctrl, stpwm_sine_rom, stpwm_out.
//
// Usage:
//   i_tick carries one sample tick per transfer; restart = 1 reloads both start
//   phases and clears the tick counter before the tick is processed.
//   o_result returns exactly one result per tick: drive, the scaled sine and
//   triangle carrier levels (signed Q1.15), last and running.
//   Registers are written through i_cfg_we / i_cfg_index / i_cfg_data while the
//   block is idle; indexes 6 and 7 are ignored.
// Pipeline and throughput:
//   A tick's result is registered first in the sine ROM read register and the
//   stage-one register, then in the result register. One tick is taken every
//   cycle while the result register is not stalled.
// Reset:
//   Phases and the counter clear, the block is idle until a restart, gain
//   returns to 31130 and all other registers to zero.
// Back-pressure:
//   A stalled result holds in the output register; the stage in front of it
//   still fills, so i_tick.ready drops only once both stages hold an item.
`default_nettype none

module sine_triangle_pwm_generator #(
    parameter int PHASE_BITS = stpwm_pkg::PHASE_BITS_DEF,
    parameter int TABLE_BITS = stpwm_pkg::TABLE_BITS_DEF,
    parameter int COUNT_BITS = stpwm_pkg::COUNT_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [stpwm_pkg::IDX_W-1:0]    i_cfg_index,
    input  wire logic [stpwm_pkg::CFG_W-1:0]    i_cfg_data,
    stpwm_in_if.sink                            i_tick,
    stpwm_out_if.source                         o_result
);
    import stpwm_pkg::*;

    logic [CFG_W-1:0]   r_sine_step;
    logic [CFG_W-1:0]   r_carrier_step;
    logic [GAIN_W-1:0]  r_sine_gain;
    logic [TOTAL_W-1:0] r_sample_total;
    logic [CFG_W-1:0]   r_sine_start;
    logic [CFG_W-1:0]   r_carrier_start;

    logic                  w_accept;
    logic                  w_s1_en;
    logic                  w_s2_en;
    logic [TABLE_BITS-1:0] w_rom_addr;
    logic                  w_rom_en;
    logic [ROM_W-1:0]      w_rom_data;
    t_s1                   w_s1;
    logic                  w_s1_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sine_step     <= '0;
            r_carrier_step  <= '0;
            r_sine_gain     <= GAIN_RESET;
            r_sample_total  <= '0;
            r_sine_start    <= '0;
            r_carrier_start <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SINE_STEP:     r_sine_step     <= i_cfg_data;
                CFG_CARRIER_STEP:  r_carrier_step  <= i_cfg_data;
                CFG_SINE_GAIN:     r_sine_gain     <= i_cfg_data[GAIN_W-1:0];
                CFG_SAMPLE_TOTAL:  r_sample_total  <= i_cfg_data[TOTAL_W-1:0];
                CFG_SINE_START:    r_sine_start    <= i_cfg_data;
                CFG_CARRIER_START: r_carrier_start <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_s1_en      = !w_s1_valid || w_s2_en;
    assign i_tick.ready = w_s1_en;
    assign w_accept     = i_tick.valid && w_s1_en;

    stpwm_ctrl #(
        .PHASE_BITS (PHASE_BITS),
        .TABLE_BITS (TABLE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_restart       (i_tick.restart),
        .i_s1_en         (w_s1_en),
        .i_sine_step     (r_sine_step),
        .i_carrier_step  (r_carrier_step),
        .i_sample_total  (r_sample_total),
        .i_sine_start    (r_sine_start),
        .i_carrier_start (r_carrier_start),
        .o_rom_addr      (w_rom_addr),
        .o_rom_en        (w_rom_en),
        .o_s1            (w_s1),
        .o_s1_valid      (w_s1_valid)
    );

    stpwm_sine_rom #(
        .TABLE_BITS (TABLE_BITS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (w_rom_en),
        .i_addr (w_rom_addr),
        .o_data (w_rom_data)
    );

    stpwm_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (w_s1_valid),
        .i_s1       (w_s1),
        .i_rom_data (w_rom_data),
        .i_gain     (r_sine_gain),
        .o_s2_en    (w_s2_en),
        .o_result   (o_result)
    );

endmodule

`default_nettype wire
